// ===== hdl/assert_macros.svh =====
// Assertion macros used by the generator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== hdl/tgfsr_pkg.sv =====
package tgfsr_pkg;

    localparam int STATE_WORDS  = 25;
    localparam int TWIST_OFFSET = 7;

    localparam logic [31:0] TWIST_CONST   = 32'h8ebf_d028;
    localparam logic [31:0] TEMPER_MASK_B = 32'h2b5b_2500;
    localparam logic [31:0] TEMPER_MASK_C = 32'hdb8b_0000;
    localparam logic [31:0] LCG_MUL       = 32'd1313;
    localparam logic [31:0] LCG_ADD       = 32'd88897;
    localparam logic [31:0] RESET_SEED    = 32'd1;

    typedef logic [31:0] word_t;

    // New word from the word being replaced and the word seven places on.
    function automatic word_t twist(input word_t old_w, input word_t far_w);
        twist = far_w ^ (old_w >> 1) ^ (old_w[0] ? TWIST_CONST : 32'd0);
    endfunction

    function automatic word_t temper(input word_t w);
        word_t y;
        y = w ^ ((w << 7) & TEMPER_MASK_B);
        temper = y ^ ((y << 15) & TEMPER_MASK_C);
    endfunction

endpackage

// ===== hdl/tgfsr_random_generator_core.sv =====
// A request item's reads land in the stage-1 registers, and its result in the output register.
// Throughput: one item per cycle while the output is not stalled and no fill runs;
// two copies of the word memory give the two reads (current word and the word seven
// places on) each cycle, written back in stage 1. Reset and each seed write refill the
// 25 words from the LCG; s_ready stays low during the fill, then the position stands at 24.
`include "assert_macros.svh"

module tgfsr_random_generator_core #(
    parameter int STATE_WORDS = tgfsr_pkg::STATE_WORDS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_clear_top_bit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value
);

    localparam int AW = $clog2(STATE_WORDS);
    localparam logic [AW-1:0] LAST      = AW'(STATE_WORDS - 1);
    localparam logic [AW:0]   WORDS_EXT = (AW + 1)'(STATE_WORDS);
    localparam logic [AW:0]   OFFSET    = (AW + 1)'(tgfsr_pkg::TWIST_OFFSET);

    tgfsr_pkg::word_t mem_a [STATE_WORDS];
    tgfsr_pkg::word_t mem_b [STATE_WORDS];

    logic             fill_active_reg;
    logic [AW-1:0]    fill_idx_reg;
    tgfsr_pkg::word_t fill_val_reg;

    logic [AW-1:0]    position_reg;
    logic             s1_valid_reg;
    logic [AW-1:0]    s1_p_reg;
    logic             s1_clear_reg;
    tgfsr_pkg::word_t rd_a_reg;
    tgfsr_pkg::word_t rd_b_reg;

    logic             m_valid_reg;
    tgfsr_pkg::word_t m_value_reg;

    logic             s1_go;
    logic             accept;
    logic [AW-1:0]    p_next;
    logic [AW:0]      q_sum;
    logic [AW-1:0]    q_addr;
    tgfsr_pkg::word_t w_new;
    tgfsr_pkg::word_t y_tmp;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    tgfsr_pkg::word_t mem_wd;

    assign cfg_ready = 1'b1;
    assign s1_go     = !m_valid_reg || m_ready;
    assign s_ready   = !fill_active_reg && (!s1_valid_reg || s1_go);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_value   = m_value_reg;

    always_comb begin
        p_next = (position_reg >= LAST) ? '0 : position_reg + 1'b1;
        q_sum  = {1'b0, p_next} + OFFSET;
        if (q_sum >= WORDS_EXT) begin
            q_sum = q_sum - WORDS_EXT;
        end
        q_addr = q_sum[AW-1:0];
    end

    always_comb begin
        w_new = tgfsr_pkg::twist(rd_a_reg, rd_b_reg);
        y_tmp = tgfsr_pkg::temper(w_new);
    end

    // Fill takes the write port; otherwise write back the twisted word.
    always_comb begin
        if (fill_active_reg) begin
            mem_we = 1'b1;
            mem_wa = fill_idx_reg;
            mem_wd = fill_val_reg;
        end else begin
            mem_we = s1_valid_reg && s1_go;
            mem_wa = s1_p_reg;
            mem_wd = w_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_a[mem_wa] <= mem_wd;
            mem_b[mem_wa] <= mem_wd;
        end
        if (accept) begin
            rd_a_reg <= mem_a[p_next];
            rd_b_reg <= mem_b[q_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_active_reg <= 1'b1;
            fill_idx_reg    <= '0;
            fill_val_reg    <= tgfsr_pkg::RESET_SEED;
            position_reg    <= LAST;
        end else if (cfg_valid && cfg_ready) begin
            fill_active_reg <= 1'b1;
            fill_idx_reg    <= '0;
            fill_val_reg    <= cfg_data;
            position_reg    <= LAST;
        end else begin
            if (fill_active_reg) begin
                fill_val_reg <= fill_val_reg * tgfsr_pkg::LCG_MUL + tgfsr_pkg::LCG_ADD;
                fill_idx_reg <= fill_idx_reg + 1'b1;
                if (fill_idx_reg == LAST) begin
                    fill_active_reg <= 1'b0;
                end
            end
            if (accept) begin
                position_reg <= p_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_p_reg     <= p_next;
            s1_clear_reg <= s_clear_top_bit;
        end
        if (s1_valid_reg && s1_go) begin
            m_value_reg <= {y_tmp[31] & ~s1_clear_reg, y_tmp[30:0]};
        end
    end

    `ASSERT_CLK(a_stall_holds, aclk, aresetn,
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_p_reg) && $stable(rd_a_reg))
    `ASSERT_CLK(a_read_in_range, aclk, aresetn,
        accept |-> p_next <= LAST && q_addr <= LAST && q_addr != p_next)
    `ASSERT_CLK(a_fill_ends_at_last, aclk, aresetn,
        $fell(fill_active_reg) |-> position_reg == LAST && !s1_valid_reg)
    `ASSERT_ALWAYS(a_no_item_in_fill, aclk,
        fill_active_reg |-> !s_ready)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_AT      = 1100;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_LIMIT = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_clear_top_bit = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_value;

    tgfsr_random_generator_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_clear_top_bit (s_clear_top_bit),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the generator state
    tgfsr_pkg::word_t gen_words [tgfsr_pkg::STATE_WORDS];
    int unsigned      gen_pos;

    bit               request_queue [$];
    tgfsr_pkg::word_t seed_queue [$];
    tgfsr_pkg::word_t expected_values [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned seeds_written = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned hold_left     = 0;
    bit          hold_used     = 1'b0;
    int unsigned quiet_cycles  = 0;

    function automatic void reseed_words(input tgfsr_pkg::word_t s);
        tgfsr_pkg::word_t v;
        v = s;
        for (int i = 0; i < tgfsr_pkg::STATE_WORDS; i++) begin
            gen_words[i] = v;
            v = v * 32'd1313 + 32'd88897;
        end
        gen_pos = tgfsr_pkg::STATE_WORDS - 1;
    endfunction

    function automatic tgfsr_pkg::word_t draw_word(input bit clear_top);
        int unsigned      far_pos;
        tgfsr_pkg::word_t old_w;
        tgfsr_pkg::word_t w;
        tgfsr_pkg::word_t y;
        gen_pos = (gen_pos + 1 >= tgfsr_pkg::STATE_WORDS) ? 0 : gen_pos + 1;
        far_pos = (gen_pos + 7) % tgfsr_pkg::STATE_WORDS;
        old_w = gen_words[gen_pos];
        w = gen_words[far_pos] ^ (old_w >> 1) ^ (old_w[0] ? 32'h8ebf_d028 : 32'h0);
        gen_words[gen_pos] = w;
        y = w ^ ((w << 7) & 32'h2b5b_2500);
        y = y ^ ((y << 15) & 32'hdb8b_0000);
        if (clear_top)
            y[31] = 1'b0;
        return y;
    endfunction

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_values.push_back(draw_word(s_clear_top_bit));
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_clear_top_bit <= request_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Seed writer
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                reseed_words(cfg_data);
                seeds_written <= seeds_written + 1;
            end
            if (!cfg_valid || cfg_ready) begin
                if (seed_queue.size() != 0) begin
                    cfg_valid <= 1'b1;
                    cfg_data <= seed_queue.pop_front();
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        tgfsr_pkg::word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_values.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected item: value %h", m_value);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_values.pop_front();
                    if (m_value !== want) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("value mismatch: expected %h, got %h", want, m_value);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            // Long hold-off so the core backs up and stalls its input
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_used && results_seen >= HOLD_AT) begin
                hold_used <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("tgfsr_random_generator_core regression: fail");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (request_queue.size() != 0 || s_valid || expected_values.size() != 0
               || seed_queue.size() != 0 || cfg_valid)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic run_seed(input tgfsr_pkg::word_t s, input int n);
        int unsigned done_before;
        wait_drained();
        done_before = seeds_written;
        seed_queue.push_back(s);
        while (seeds_written == done_before)
            @(negedge aclk);
        for (int i = 0; i < n; i++)
            request_queue.push_back(1'($urandom_range(1, 0)));
    endtask

    initial begin
        reseed_words(32'd1);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset seed: both request kinds, back to back and alternating
        for (int i = 0; i < 24; i++)
            request_queue.push_back(i < 4 ? 1'b0 : (i < 8 ? 1'b1 : 1'(i % 2)));

        send_idle_pct = 34;
        recv_idle_pct = 64;
        run_seed(32'h0000_0000, 150);
        run_seed(32'hffff_ffff, 150);
        run_seed($urandom, 150);

        wait_drained();
        send_idle_pct = 64;
        recv_idle_pct = 34;
        run_seed(32'd1, 150);
        run_seed(32'h8000_0000, 150);
        run_seed($urandom, 150);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_seed($urandom, 250);
        run_seed($urandom, 250);

        wait_drained();
        repeat (10) @(negedge aclk);
        if (mismatches == 0 && expected_values.size() == 0)
            $display("tgfsr_random_generator_core regression: pass");
        else
            $display("tgfsr_random_generator_core regression: fail");
        $finish;
    end

endmodule
